FILE: hw/rtl/four_channel_poly_sound_generator_defines.svh
// Assertion macros for the four-channel sound generator.
// Used by the port checker; depends on nothing.
`ifndef FOUR_CHANNEL_POLY_SOUND_GENERATOR_DEFINES_SVH
`define FOUR_CHANNEL_POLY_SOUND_GENERATOR_DEFINES_SVH

// check cons in the same cycle as ante, outside reset
`define FCPSG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante, outside reset
`define FCPSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// check cons in the cycle after ante, reset included
`define FCPSG_ASSERT_AFTER(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/fcpsg_pkg.sv
// Shared types and constants of the four-channel sound generator.
// Depends on nothing.
`default_nettype none

package fcpsg_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int CH_IDX_W     = 2;

   typedef logic [7:0] byte_type;
   typedef logic [NUM_CHANNELS-1:0][7:0] chan_byte_type;
   typedef logic [3:0] addr_type;

   typedef enum logic {
      ACTION_WRITE = 1'b0,
      ACTION_TICK  = 1'b1
   } action_type;

   localparam addr_type REG_CHANNEL_END = 4'd8;
   localparam addr_type REG_RELOAD      = 4'd9;

   localparam int CTL_VOLUME_ONLY = 4;

   localparam logic [3:0]  LFSR4_SEED  = 4'hF;
   localparam logic [4:0]  LFSR5_SEED  = 5'h1F;
   localparam logic [8:0]  LFSR9_SEED  = 9'h1FF;
   localparam logic [16:0] LFSR17_SEED = 17'h1FFFF;

   localparam logic [15:0] GATE_MASK [8] = '{
      16'hCC00, 16'hCCCC, 16'hAA00, 16'hAAAA,
      16'hFF00, 16'hFFFF, 16'hF0F0, 16'hFFFF
   };

endpackage

`default_nettype wire

FILE: hw/rtl/fcpsg_req_if.sv
// Request channel: register write or audio tick, valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface fcpsg_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [3:0] register_address;
   logic [7:0] write_data;

   modport source (output valid, action, register_address, write_data, input ready);
   modport sink   (input valid, action, register_address, write_data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fcpsg_rsp_if.sv
// Response channel: one mixed sample per tick, valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface fcpsg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/four_channel_poly_sound_generator.sv
// Four-channel square and noise sound generator; uses fcpsg_pkg and the channel interfaces.
// Output: a tick's sample goes to the output register, or to the skid entry while a sample waits there.
// Throughput: one request per cycle; an output register plus one skid entry
// keep requests flowing while a sample waits, ready drops only when both are full.
// Reset (synchronous): LFSRs to all ones, channel state and output buffer cleared.
`default_nettype none

module four_channel_poly_sound_generator
   import fcpsg_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   fcpsg_req_if.sink   req_ch,
   fcpsg_rsp_if.source rsp_ch
);

   chan_byte_type             ctrl_ff, ctrl_in;
   chan_byte_type             divisor_ff, divisor_in;
   chan_byte_type             counter_ff, counter_in;
   logic [NUM_CHANNELS-1:0]   level_ff, level_in;
   logic [3:0]                lfsr4_ff, lfsr4_in;
   logic [4:0]                lfsr5_ff, lfsr5_in;
   logic [8:0]                lfsr9_ff, lfsr9_in;
   logic [16:0]               lfsr17_ff, lfsr17_in;

   logic                      out_valid_ff, out_valid_in;
   byte_type                  out_sample_ff, out_sample_in;
   logic                      skid_valid_ff, skid_valid_in;
   byte_type                  skid_sample_ff, skid_sample_in;

   logic [3:0]                lfsr4_step;
   logic [4:0]                lfsr5_step;
   logic [8:0]                lfsr9_step;
   logic [16:0]               lfsr17_step;
   logic [3:0]                gate_sel;
   chan_byte_type             counter_step;
   logic [NUM_CHANNELS-1:0]   level_step;
   logic [5:0]                total;
   byte_type                  sample_calc;

   logic                      accept;
   logic                      push;
   logic                      pop;
   logic [CH_IDX_W-1:0]       wr_chan;

   assign accept  = req_ch.valid && req_ch.ready;
   assign push    = accept && (req_ch.action == ACTION_TICK);
   assign pop     = out_valid_ff && rsp_ch.ready;
   assign wr_chan = req_ch.register_address[CH_IDX_W:1];

   assign req_ch.ready  = !skid_valid_ff;
   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.sample = out_sample_ff;

   assign lfsr4_step  = {lfsr4_ff[2:0], lfsr4_ff[3] ^ lfsr4_ff[2]};
   assign lfsr5_step  = {lfsr5_ff[3:0], lfsr5_ff[4] ^ lfsr5_ff[2]};
   assign lfsr9_step  = {lfsr9_ff[7:0], lfsr9_ff[8] ^ lfsr9_ff[4]};
   assign lfsr17_step = {lfsr17_ff[15:0], lfsr17_ff[16] ^ lfsr17_ff[13]};
   assign gate_sel    = {lfsr17_step[0], lfsr9_step[0], lfsr5_step[0], lfsr4_step[0]};

   always_comb begin
      total = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (!ctrl_ff[i][CTL_VOLUME_ONLY]) begin
            if (counter_ff[i] == '0) begin
               counter_step[i] = divisor_ff[i];
               level_step[i]   = !level_ff[i];
            end else begin
               counter_step[i] = counter_ff[i] - 8'd1;
               level_step[i]   = level_ff[i];
            end
         end else begin
            counter_step[i] = counter_ff[i];
            level_step[i]   = 1'b1;
         end
         if (level_step[i] && GATE_MASK[ctrl_ff[i][7:5]][gate_sel]) begin
            total = total + {2'b00, ctrl_ff[i][3:0]};
         end
      end
      sample_calc = {total, 2'b00} + {4'b0000, total[5:2]};
   end

   always_comb begin
      ctrl_in    = ctrl_ff;
      divisor_in = divisor_ff;
      counter_in = counter_ff;
      level_in   = level_ff;
      lfsr4_in   = lfsr4_ff;
      lfsr5_in   = lfsr5_ff;
      lfsr9_in   = lfsr9_ff;
      lfsr17_in  = lfsr17_ff;
      if (accept) begin
         if (req_ch.action == ACTION_TICK) begin
            counter_in = counter_step;
            level_in   = level_step;
            lfsr4_in   = lfsr4_step;
            lfsr5_in   = lfsr5_step;
            lfsr9_in   = lfsr9_step;
            lfsr17_in  = lfsr17_step;
         end else if (req_ch.register_address < REG_CHANNEL_END) begin
            if (req_ch.register_address[0]) begin
               ctrl_in[wr_chan] = req_ch.write_data;
            end else begin
               divisor_in[wr_chan] = req_ch.write_data;
            end
         end else if (req_ch.register_address == REG_RELOAD) begin
            counter_in = divisor_ff;
         end
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_sample_in  = out_sample_ff;
      skid_valid_in  = skid_valid_ff;
      skid_sample_in = skid_sample_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_sample_in = skid_sample_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = push;
            out_sample_in = sample_calc;
         end
      end else if (push) begin
         skid_valid_in  = 1'b1;
         skid_sample_in = sample_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff       <= '0;
         divisor_ff    <= '0;
         counter_ff    <= '0;
         level_ff      <= '0;
         lfsr4_ff      <= LFSR4_SEED;
         lfsr5_ff      <= LFSR5_SEED;
         lfsr9_ff      <= LFSR9_SEED;
         lfsr17_ff     <= LFSR17_SEED;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         ctrl_ff       <= ctrl_in;
         divisor_ff    <= divisor_in;
         counter_ff    <= counter_in;
         level_ff      <= level_in;
         lfsr4_ff      <= lfsr4_in;
         lfsr5_ff      <= lfsr5_in;
         lfsr9_ff      <= lfsr9_in;
         lfsr17_ff     <= lfsr17_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sample_ff  <= out_sample_in;
      skid_sample_ff <= skid_sample_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/fcpsg_checker.sv
// Port-level checks of the four-channel sound generator, bound to the top level.
// Depends on fcpsg_pkg and four_channel_poly_sound_generator_defines.svh.
`default_nettype none
`include "four_channel_poly_sound_generator_defines.svh"

module fcpsg_checker
   import fcpsg_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_action,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_sample
);

   logic req_take;
   logic tick_take;
   logic write_take;

   assign req_take   = req_valid && req_ready;
   assign tick_take  = req_take && (req_action == ACTION_TICK);
   assign write_take = req_take && (req_action == ACTION_WRITE);

   `FCPSG_ASSERT_AFTER(a_reset_clears, clock, reset, req_ready && !rsp_valid, "reset must empty the output buffer")
   `FCPSG_ASSERT_NEXT(a_tick_responds, clock, reset, tick_take, rsp_valid, "tick request gave no sample")
   `FCPSG_ASSERT_NEXT(a_write_silent, clock, reset, write_take && !rsp_valid, !rsp_valid, "write request produced a sample")
   `FCPSG_ASSERT_SAME(a_stall_needs_data, clock, reset, !req_ready, rsp_valid, "request stalled with no sample pending")
   `FCPSG_ASSERT_NEXT(a_sample_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample), "stalled sample changed")

endmodule

bind four_channel_poly_sound_generator fcpsg_checker u_fcpsg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_action (req_ch.action),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_sample (rsp_ch.sample)
);

`default_nettype wire
